// ----- hdl/assert_macros.svh -----
// Assertion macros for the keyframe curve sampler checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define KCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define KCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/kcs_pkg.sv -----
// Shared types and constants of the keyframe curve sampler.
// No dependencies.
package kcs_pkg;

    localparam int MAX_KEYS    = 16;
    localparam int KEY_AW      = $clog2(MAX_KEYS);
    localparam int KEY_COUNT_W = 5;
    localparam int DATA_W      = 32;
    localparam int X_W         = 17;
    localparam int APB_AW      = 3;

    localparam logic       MODE_WRITE      = 1'b0;
    localparam logic       MODE_SAMPLE     = 1'b1;
    localparam logic [1:0] IM_FLAT         = 2'd0;
    localparam logic [1:0] IM_LINEAR       = 2'd1;
    localparam logic [1:0] IM_SMOOTH       = 2'd2;
    localparam logic [0:0] REG_INTERP_MODE = 1'b0;
    localparam logic [0:0] REG_KEY_COUNT   = 1'b1;
    localparam logic [17:0] SMOOTH_K       = 18'd196608;

    typedef enum logic [2:0] {
        OUT_NONE  = 3'd0,
        OUT_RIGHT = 3'd1,
        OUT_LEFT  = 3'd2,
        OUT_SAME  = 3'd3,
        OUT_BLEND = 3'd4
    } outcome_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VRD_A,
        ST_VRD_B,
        ST_VRD_C,
        ST_DIV,
        ST_WGT,
        ST_SQ,
        ST_CUBE,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/kcs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module kcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/keyframe_curve_sampler.sv -----
// Keyframe curve sampler: a write transaction stores one key and leaves the input ready. A
// sample scans the keys and reads the bracketing values; a blend also runs a restoring division
// with a 17-bit quotient, and smoothstep adds a square and a cube step before the multiply.
// Input is ready again in the cycle after the result is loaded; a held result stalls that load.
// Synchronous active-low reset returns interp_mode and key_count to 1; the key
// RAMs are not cleared. Depends on kcs_pkg and kcs_ram.
module keyframe_curve_sampler
    import kcs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_mode,
    input  logic [3:0]             s_key_index,
    input  logic signed [31:0]     s_key_time,
    input  logic signed [31:0]     s_key_value,
    input  logic signed [31:0]     s_sample_time,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [31:0]     m_sample_value,
    output logic [2:0]             m_outcome
);

    state_t state_reg, state_next;
    logic [1:0]             interp_mode_reg;
    logic [KEY_COUNT_W-1:0] key_count_reg;
    logic [KEY_COUNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [KEY_AW-1:0]      chk_idx_reg, chk_idx_next;
    logic                   left_vld_reg, left_vld_next, right_vld_reg, right_vld_next;
    logic [KEY_AW-1:0]      left_idx_reg, left_idx_next, right_idx_reg, right_idx_next;
    logic [31:0]            t_reg, t_next, tl_reg, tl_next, tr_reg, tr_next;
    logic [31:0]            vl_reg, vl_next, vr_reg, vr_next, res_reg, res_next;
    outcome_t               code_reg, code_next;
    logic [33:0]            r_reg, r_next;
    logic [32:0]            den_reg, den_next;
    logic [X_W-1:0]         q_reg, q_next, w_reg, w_next;
    logic [4:0]             div_cnt_reg, div_cnt_next;
    logic [33:0]            x2_reg, x2_next;
    logic [50:0]            p_reg, p_next;
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            m_value_reg, m_value_next;
    outcome_t               m_outcome_reg, m_outcome_next;

    logic [KEY_COUNT_W-1:0] n_keys;
    logic                   s_accept, cfg_wr;
    logic [KEY_AW-1:0]      t_raddr, v_raddr;
    logic [31:0]            t_rdata, v_rdata;
    logic                   div_ge;
    logic [33:0]            r_sub;
    logic [32:0]            num33, den33, diff33;
    logic [17:0]            coef;
    logic [51:0]            cube;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign n_keys   = (key_count_reg > KEY_COUNT_W'(MAX_KEYS)) ?
                      KEY_COUNT_W'(MAX_KEYS) : key_count_reg;

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_value_reg;
    assign m_outcome      = m_outcome_reg;

    always_comb begin
        unique case (paddr[2])
            REG_INTERP_MODE: prdata = {30'd0, interp_mode_reg};
            default:         prdata = {{(32 - KEY_COUNT_W){1'b0}}, key_count_reg};
        endcase
    end

    kcs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_time_ram (
        .aclk (aclk),
        .we   (s_accept && s_mode == MODE_WRITE),
        .waddr(s_key_index),
        .wdata(s_key_time),
        .raddr(t_raddr),
        .rdata(t_rdata)
    );

    kcs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) u_value_ram (
        .aclk (aclk),
        .we   (s_accept && s_mode == MODE_WRITE),
        .waddr(s_key_index),
        .wdata(s_key_value),
        .raddr(v_raddr),
        .rdata(v_rdata)
    );

    assign t_raddr = scan_cnt_reg[KEY_AW-1:0];
    assign v_raddr = (state_reg == ST_VRD_A && left_vld_reg) ? left_idx_reg : right_idx_reg;

    assign div_ge = (r_reg >= {1'b0, den_reg});
    assign r_sub  = div_ge ? (r_reg - {1'b0, den_reg}) : r_reg;
    assign num33  = {t_reg[31], t_reg} - {tl_reg[31], tl_reg};
    assign den33  = {tr_reg[31], tr_reg} - {tl_reg[31], tl_reg};
    assign diff33 = {vr_reg[31], vr_reg} - {vl_reg[31], vl_reg};
    assign coef   = SMOOTH_K - {w_reg, 1'b0};
    assign cube   = x2_reg * coef;

    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        left_vld_next  = left_vld_reg;
        left_idx_next  = left_idx_reg;
        right_vld_next = right_vld_reg;
        right_idx_next = right_idx_reg;
        t_next         = t_reg;
        tl_next        = tl_reg;
        tr_next        = tr_reg;
        vl_next        = vl_reg;
        vr_next        = vr_reg;
        res_next       = res_reg;
        code_next      = code_reg;
        r_next         = r_reg;
        den_next       = den_reg;
        q_next         = q_reg;
        w_next         = w_reg;
        div_cnt_next   = div_cnt_reg;
        x2_next        = x2_reg;
        p_next         = p_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_value_next   = m_value_reg;
        m_outcome_next = m_outcome_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_mode == MODE_SAMPLE) begin
                    t_next         = s_sample_time;
                    scan_cnt_next  = '0;
                    left_vld_next  = 1'b0;
                    right_vld_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (chk_vld_reg) begin
                    if ($signed(t_rdata) <= $signed(t_reg)) begin
                        left_vld_next = 1'b1;
                        left_idx_next = chk_idx_reg;
                        tl_next       = t_rdata;
                    end
                    if (!right_vld_reg && $signed(t_rdata) >= $signed(t_reg)) begin
                        right_vld_next = 1'b1;
                        right_idx_next = chk_idx_reg;
                        tr_next        = t_rdata;
                    end
                end
                if (scan_cnt_reg < n_keys) begin
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_cnt_reg[KEY_AW-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end else if (!chk_vld_reg) begin
                    state_next = ST_VRD_A;
                end
            end
            ST_VRD_A: begin
                priority if (!left_vld_reg && !right_vld_reg) begin
                    code_next  = OUT_NONE;
                    res_next   = '0;
                    state_next = ST_DONE;
                end else if (!left_vld_reg) begin
                    code_next  = OUT_RIGHT;
                    state_next = ST_VRD_B;
                end else if (!right_vld_reg) begin
                    code_next  = OUT_LEFT;
                    state_next = ST_VRD_B;
                end else if (left_idx_reg == right_idx_reg) begin
                    code_next  = OUT_SAME;
                    state_next = ST_VRD_B;
                end else begin
                    code_next  = OUT_BLEND;
                    state_next = ST_VRD_B;
                end
            end
            ST_VRD_B: begin
                if (code_reg != OUT_BLEND) begin
                    res_next   = v_rdata;
                    state_next = ST_DONE;
                end else begin
                    vl_next    = v_rdata;
                    state_next = ST_VRD_C;
                end
            end
            ST_VRD_C: begin
                vr_next      = v_rdata;
                r_next       = {1'b0, num33};
                den_next     = den33;
                q_next       = '0;
                div_cnt_next = '0;
                if (den33 == '0) begin
                    q_next     = '0;
                    state_next = ST_WGT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring division, quotient <= 1.0 since tl <= t <= tr
                r_next       = {r_sub[32:0], 1'b0};
                q_next       = {q_reg[X_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 5'(X_W - 1)) begin
                    state_next = ST_WGT;
                end
            end
            ST_WGT: begin
                unique case (interp_mode_reg)
                    IM_FLAT: begin
                        w_next     = '0;
                        state_next = ST_MUL;
                    end
                    IM_SMOOTH: begin
                        w_next     = q_reg;
                        state_next = ST_SQ;
                    end
                    default: begin
                        w_next     = q_reg;
                        state_next = ST_MUL;
                    end
                endcase
            end
            ST_SQ: begin
                x2_next    = {17'd0, w_reg} * {17'd0, w_reg};
                state_next = ST_CUBE;
            end
            ST_CUBE: begin
                w_next     = cube[48:32];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                p_next     = $signed({1'b0, w_reg}) * $signed(diff33);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                res_next   = vl_reg + p_reg[47:16];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_value_next   = res_reg;
                    m_outcome_next = code_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            interp_mode_reg <= IM_LINEAR;
            key_count_reg   <= KEY_COUNT_W'(1);
            chk_vld_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_INTERP_MODE: interp_mode_reg <= pwdata[1:0];
                    default:         key_count_reg   <= pwdata[KEY_COUNT_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg   <= scan_cnt_next;
        chk_idx_reg    <= chk_idx_next;
        left_vld_reg   <= left_vld_next;
        left_idx_reg   <= left_idx_next;
        right_vld_reg  <= right_vld_next;
        right_idx_reg  <= right_idx_next;
        t_reg          <= t_next;
        tl_reg         <= tl_next;
        tr_reg         <= tr_next;
        vl_reg         <= vl_next;
        vr_reg         <= vr_next;
        res_reg        <= res_next;
        code_reg       <= code_next;
        r_reg          <= r_next;
        den_reg        <= den_next;
        q_reg          <= q_next;
        w_reg          <= w_next;
        div_cnt_reg    <= div_cnt_next;
        x2_reg         <= x2_next;
        p_reg          <= p_next;
        m_value_reg    <= m_value_next;
        m_outcome_reg  <= m_outcome_next;
    end

endmodule

// ----- hdl/kcs_checker.sv -----
// Port-level assertions for keyframe_curve_sampler, bound to the top level.
// Depends on kcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kcs_checker
    import kcs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_mode,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_sample_value,
    input logic [2:0]         m_outcome
);

    `KCS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_sample_value) && $stable(m_outcome), "stalled result transaction changed")
    `KCS_ASSERT(a_busy_after_sample, aclk, aresetn, s_valid && s_ready && s_mode == MODE_SAMPLE |=> !s_ready, "sample accepted but input still ready")
    `KCS_ASSERT(a_outcome_code, aclk, aresetn, m_valid |-> m_outcome <= OUT_BLEND, "outcome code out of range")
    `KCS_ASSERT(a_none_is_zero, aclk, aresetn, m_valid && m_outcome == OUT_NONE |-> m_sample_value == 0, "no-key result is not zero")

endmodule

bind keyframe_curve_sampler kcs_checker u_kcs_checker (.*);
